/* rtl/qpht_pkg.sv */
// Shared types and constants for the quadratic probing hash table.
package qpht_pkg;

	localparam int MAX_SLOTS_DEF = 1024;
	localparam int CFG_W = 11;
	localparam int KEY_W = 31;
	localparam int SLOT_W = 10;
	localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1021;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] key;
	} qpht_req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} qpht_rsp_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic probe_start;
		logic probe_next;
		logic res_set;
		logic res_hit;
		logic out_load;
		logic clr_step;
	} qpht_ctl_t;

	typedef struct packed {
		logic div_last;
		logic key_zero;
		logic match;
		logic more;
		logic clr_last;
	} qpht_sts_t;

endpackage

/* rtl/quadratic_probe_hash_table.sv */
// Open-addressed hash table of positive keys with quadratic probing; top level.
// Each transaction inserts or looks up one key and returns one response. After reset the
// block sweeps the slot memory to empty, one slot a cycle, with req_ready low; table_size
// writes are taken during that time. A transaction first runs the remainder unit, which
// forms key mod the size (table_size held to 1..MAX_SLOTS) and retires four key bits a
// cycle, then the probe walk, which visits one slot a cycle, bounded by the single read
// port of the slot memory, and then loads its response. A zero key skips the walk. One
// transaction is in flight at a time, and a finished response waits in an output
// register while the next request is taken.
module quadratic_probe_hash_table import qpht_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             req_valid,
	output logic             req_ready,
	input  qpht_req_t        req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output qpht_rsp_t        rsp
);

	qpht_ctl_t ctl;
	qpht_sts_t sts;

	qpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	qpht_dp #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.req     (req),
		.ctl     (ctl),
		.sts     (sts),
		.rsp     (rsp)
	);

endmodule

/* rtl/qpht_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module qpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/qpht_ctrl.sv */
// Controller state machine that sequences clearing, remainder, probing and response.
module qpht_ctrl import qpht_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  qpht_sts_t sts,
	output qpht_ctl_t ctl
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					ctl.load = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				ctl.div_step = 1'b1;
				if (sts.div_last) begin
					if (sts.key_zero) begin
						ctl.res_set = 1'b1;
						state_d = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				ctl.probe_start = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.match) begin
					ctl.res_set = 1'b1;
					ctl.res_hit = 1'b1;
					state_d = S_DONE;
				end else if (sts.more) begin
					ctl.probe_next = 1'b1;
				end else begin
					ctl.res_set = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					ctl.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/qpht_dp.sv */
// Datapath with size register, remainder unit, probe address generator and slot memory.
module qpht_dp import qpht_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	input  qpht_req_t        req,
	input  qpht_ctl_t        ctl,
	output qpht_sts_t        sts,
	output qpht_rsp_t        rsp
);

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int NW = AW + 1;
	localparam int SW = (NW > CFG_W) ? NW : CFG_W;

	logic [CFG_W-1:0] table_size_q;
	logic [NW-1:0]    n;
	logic [NW-1:0]    half;
	logic [SW-1:0]    ts_ext;

	logic             op_q;
	logic [KEY_W-1:0] key_q;
	logic [31:0]      kshift_q;
	logic [2:0]       div_cnt_q;
	logic [NW-1:0]    r_q;
	logic [NW-1:0]    r_d;
	logic [NW:0]      r_t;

	logic [AW-1:0]    p_q;
	logic [AW-1:0]    d_q;
	logic [NW-1:0]    i_q;
	logic [AW:0]      p_sum;
	logic [AW:0]      d_sum;
	logic [AW-1:0]    p_next;
	logic [AW-1:0]    d_next;

	logic [AW-1:0]    clr_q;
	logic             res_hit_q;
	logic [SLOT_W-1:0] res_slot_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [KEY_W-1:0] ram_rdata;

	always_comb begin
		ts_ext = SW'(table_size_q);
		if (table_size_q == '0) begin
			n = NW'(1);
		end else if (ts_ext > SW'(MAX_SLOTS)) begin
			n = NW'(MAX_SLOTS);
		end else begin
			n = NW'(table_size_q);
		end
	end

	assign half = n >> 1;

	// Four restoring steps of key mod n per cycle, most significant bits first.
	always_comb begin
		r_t = '0;
		r_d = r_q;
		for (int k = 0; k < 4; k++) begin
			r_t = {r_d, kshift_q[31-k]};
			if (r_t >= {1'b0, n}) begin
				r_t = r_t - {1'b0, n};
			end
			r_d = r_t[NW-1:0];
		end
	end

	always_comb begin
		p_sum = {1'b0, p_q} + {1'b0, d_q};
		if (p_sum >= (AW+1)'(n)) begin
			p_sum = p_sum - (AW+1)'(n);
		end
		p_next = p_sum[AW-1:0];
		d_sum = {1'b0, d_q} + (AW+1)'(2);
		if (d_sum >= (AW+1)'(n)) begin
			d_sum = d_sum - (AW+1)'(n);
		end
		d_next = d_sum[AW-1:0];
	end

	assign sts.div_last = (div_cnt_q == 3'd7);
	assign sts.key_zero = (key_q == '0);
	assign sts.match = (op_q == OP_INSERT) ? (ram_rdata == '0) : (ram_rdata == key_q);
	assign sts.more = (NW'(i_q + 1'b1) < half);
	assign sts.clr_last = (clr_q == AW'(MAX_SLOTS - 1));

	always_comb begin
		if (ctl.probe_start) begin
			ram_raddr = r_q[AW-1:0];
		end else begin
			ram_raddr = p_next;
		end
		ram_we = ctl.clr_step || (ctl.res_set && ctl.res_hit && (op_q == OP_INSERT));
		ram_waddr = ctl.clr_step ? clr_q : p_q;
		ram_wdata = ctl.clr_step ? '0 : key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RESET;
			clr_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				table_size_q <= cfg_data;
			end
			if (ctl.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.load) begin
				div_cnt_q <= '0;
			end else if (ctl.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q <= req.cmd;
			key_q <= req.key;
			kshift_q <= {1'b0, req.key};
			r_q <= '0;
		end else if (ctl.div_step) begin
			kshift_q <= {kshift_q[27:0], 4'b0000};
			r_q <= r_d;
		end
		if (ctl.probe_start) begin
			p_q <= r_q[AW-1:0];
			d_q <= (n == NW'(1)) ? '0 : AW'(1);
			i_q <= '0;
		end else if (ctl.probe_next) begin
			p_q <= p_next;
			d_q <= d_next;
			i_q <= i_q + 1'b1;
		end
		if (ctl.res_set) begin
			res_hit_q <= ctl.res_hit;
			res_slot_q <= ctl.res_hit ? SLOT_W'(p_q) : '0;
		end
		if (ctl.out_load) begin
			rsp.hit <= res_hit_q;
			rsp.slot <= res_slot_q;
		end
	end

	qpht_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

/* rtl/qpht_checker.sv */
// Port-level assertions for the hash table top level, with the bind that attaches them.
module qpht_checker import qpht_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input qpht_req_t        req,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input qpht_rsp_t        rsp
);

	// A waiting request transaction keeps its valid and payload.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_ready) |=> (req_valid && $stable(req)))
		else $error("request changed while waiting");

	// A stalled response transaction keeps its valid and payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("response changed while stalled");

	// A miss always reports slot zero.
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.hit) |-> (rsp.slot == '0))
		else $error("miss with nonzero slot");

	// Only one request transaction is in flight, so ready drops after an accept.
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while busy");

	// A response is not produced just after a request is accepted; the remainder unit runs first.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> ##1 !$rose(rsp_valid))
		else $error("response too early");

endmodule

bind quadratic_probe_hash_table qpht_checker u_qpht_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for the quadratic probing hash table.
`timescale 1ns / 1ps

module testbench;
	import qpht_pkg::*;

	localparam int PHASES = 15;
	localparam int TAIL_CYCLES = 600;
	localparam int MAX_REPORTS = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	qpht_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	qpht_rsp_t rsp;

	logic [KEY_W-1:0] table_mem [MAX_SLOTS_DEF];
	logic [CFG_W-1:0] size_reg = TABLE_SIZE_RESET;
	qpht_rsp_t answer_q [$];
	logic [KEY_W-1:0] stored_keys [$];
	qpht_rsp_t owed;
	bit idle_on = 1'b1;
	int ready_wait = 0;
	int bad_count = 0;
	int items_sent = 0;
	int answers_seen = 0;
	int sizes_used = 0;

	int phase_size [PHASES] = '{7, 13, 2, 31, 61, 3, 127, 100, 5, 251, 509, 17, 1021,
		1500, 1024};
	int phase_len [PHASES] = '{90, 90, 40, 90, 90, 40, 90, 90, 40, 50, 50, 40, 50,
		50, 50};

	quadratic_probe_hash_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	function automatic int unsigned live_size();
		int unsigned n;
		n = size_reg;
		if (n == 0)
			n = 1;
		if (n > MAX_SLOTS_DEF)
			n = MAX_SLOTS_DEF;
		return n;
	endfunction

	function automatic bit probe_for(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] want,
			output int unsigned where);
		int unsigned n;
		int unsigned home;
		int unsigned half;
		int unsigned p;
		n = live_size();
		home = key % n;
		half = n / 2;
		where = 0;
		if (table_mem[home] == want) begin
			where = home;
			return 1'b1;
		end
		for (int unsigned i = 1; i < half; i++) begin
			p = (home + i * i) % n;
			if (table_mem[p] == want) begin
				where = p;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic qpht_rsp_t hash_access(input qpht_req_t r);
		qpht_rsp_t o;
		int unsigned where;
		bit ok;
		ok = 1'b0;
		where = 0;
		if (r.key != '0) begin
			if (r.cmd == OP_INSERT) begin
				ok = probe_for(r.key, '0, where);
				if (ok)
					table_mem[where] = r.key;
			end else begin
				ok = probe_for(r.key, r.key, where);
			end
		end
		if (!ok)
			where = 0;
		o.hit = ok;
		o.slot = where[SLOT_W-1:0];
		return o;
	endfunction

	function automatic int idle_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (ready_wait > 0) begin
			ready_wait = ready_wait - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
			ready_wait = idle_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			answers_seen++;
			if (answer_q.size() == 0) begin
				bad_count++;
				if (bad_count <= MAX_REPORTS)
					$display("%0t: unrequested response, expected none, actual hit %0b slot %0d",
						$time, rsp.hit, rsp.slot);
			end else begin
				owed = answer_q.pop_front();
				if (rsp.hit !== owed.hit || rsp.slot !== owed.slot) begin
					bad_count++;
					if (bad_count <= MAX_REPORTS)
						$display("%0t: expected hit %0b slot %0d, actual hit %0b slot %0d",
							$time, owed.hit, owed.slot, rsp.hit, rsp.slot);
				end
			end
		end
	end

	task automatic send_request(input logic op, input logic [KEY_W-1:0] k);
		int gap;
		qpht_req_t item;
		qpht_rsp_t ans;
		gap = idle_gap();
		item.cmd = op;
		item.key = k;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
		ans = hash_access(item);
		answer_q.push_back(ans);
		if (op == OP_INSERT && ans.hit)
			stored_keys.push_back(k);
		items_sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_table_size(input logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = v;
		sizes_used++;
	endtask

	// Runs at the size left by reset: collisions, a duplicate, a full miss walk, zero keys.
	task automatic test_reset_size();
		send_request(OP_INSERT, 31'd1);
		send_request(OP_INSERT, 31'h7FFF_FFFF);
		send_request(OP_INSERT, 31'd1000);
		send_request(OP_INSERT, 31'd2021);
		send_request(OP_INSERT, 31'd1000);
		send_request(OP_LOOKUP, 31'd2021);
		send_request(OP_LOOKUP, 31'd1000);
		send_request(OP_LOOKUP, 31'h7FFF_FFFF);
		send_request(OP_LOOKUP, 31'd12345);
		send_request(OP_INSERT, 31'd0);
		send_request(OP_LOOKUP, 31'd0);
		drain();
	endtask

	// Zero size, the smallest prime and a size beyond capacity; the zero size fills its table.
	task automatic test_tiny_sizes();
		write_table_size(11'd0);
		send_request(OP_INSERT, 31'd6);
		send_request(OP_INSERT, 31'd7);
		send_request(OP_LOOKUP, 31'd6);
		drain();
		write_table_size(11'd2);
		send_request(OP_INSERT, 31'd9);
		send_request(OP_LOOKUP, 31'd1);
		drain();
		write_table_size(11'd2047);
		send_request(OP_INSERT, 31'd1024);
		send_request(OP_LOOKUP, 31'h7FFF_FFFF);
		drain();
	endtask

	task automatic test_random_load();
		int unsigned n;
		int r;
		logic [KEY_W-1:0] k;
		logic op;
		for (int ph = 0; ph < PHASES; ph++) begin
			write_table_size(CFG_W'(phase_size[ph]));
			idle_on = ($urandom_range(0, 3) != 0);
			n = live_size();
			for (int j = 0; j < phase_len[ph]; j++) begin
				r = $urandom_range(0, 99);
				if ($urandom_range(0, 1))
					k = KEY_W'($urandom_range(1, 4 * n));
				else
					k = KEY_W'($urandom);
				op = OP_INSERT;
				if (r >= 40 && r < 75) begin
					op = OP_LOOKUP;
					if (stored_keys.size() != 0)
						k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
				end else if (r >= 75 && r < 85) begin
					if (stored_keys.size() != 0)
						k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
				end else if (r >= 85 && r < 95) begin
					op = OP_LOOKUP;
				end else if (r >= 95) begin
					op = $urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT;
					k = '0;
				end
				send_request(op, k);
			end
			drain();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		for (int s = 0; s < MAX_SLOTS_DEF; s++)
			table_mem[s] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_size();
		test_tiny_sizes();
		test_random_load();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("tb: %0d insert and lookup transactions over %0d table size settings,", items_sent,
			sizes_used);
		$display("tb: %0d responses compared, %0d mismatches", answers_seen, bad_count);
		if (bad_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
rtl/qpht_pkg.sv
rtl/qpht_ram.sv
rtl/qpht_ctrl.sv
rtl/qpht_dp.sv
rtl/quadratic_probe_hash_table.sv
rtl/qpht_checker.sv
tb/testbench.sv
